### design/rbfo_pkg.sv
// shared types and constants of the overwriting ring buffer fifo
// used by the top level and by the port checker; no dependencies

package rbfo_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_OVERWRITE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd1;

  // operation kind carried on the input tuser
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // field widths of one beat
  localparam int unsigned PUSH_DATA_W = 32;
  localparam int unsigned POP_DATA_W  = 32;
  localparam int unsigned FILL_W      = 5;
  localparam int unsigned OUT_PAD_W   = 3;
  localparam int unsigned OUT_TDATA_W = POP_DATA_W + FILL_W + OUT_PAD_W;
  localparam int unsigned OUT_TUSER_W = 5;

  // bit positions inside the output tuser
  localparam int unsigned TU_POP_VALID = 0;
  localparam int unsigned TU_PUSH_ACC  = 1;
  localparam int unsigned TU_OVERWROTE = 2;
  localparam int unsigned TU_EMPTY     = 3;
  localparam int unsigned TU_FULL      = 4;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_POP_WAIT
  } state_e;

endpackage

### design/rbfo_ram.sv
// generic single-write, single-read ram with a registered read port
// no dependencies

module rbfo_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ring_buffer_fifo_with_overwrite_top.sv
// top level of the ring buffer fifo with optional overwrite of the oldest element
// depends on rbfo_pkg and rbfo_ram
//
// Each input beat is one atomic operation: tuser 0 pushes tdata, tuser 1 pops
// the oldest element. Every operation returns exactly one output beat with the
// popped data, the fill count and the status flags after the operation. A push,
// a rejected push and a pop on an empty buffer go straight to the output register,
// and such beats are taken every cycle while the output side keeps up. A pop
// that returns an element passes the registered ram read and the output register,
// and no new beat is taken while that read is in flight. A write to the capacity
// register empties the buffer (stored slots are not cleared); capacity 0 acts
// as 1 and a value above DEPTH acts as DEPTH. Slots come up undefined after
// reset and there is no clearing pass. The fill count is reported modulo 32.

module ring_buffer_fifo_with_overwrite_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [rbfo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rbfo_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // operation stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rbfo_pkg::PUSH_DATA_W-1:0]  s_axis_tdata,  // [31:0] push_data
  input  logic                              s_axis_tuser,  // [0] mode
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] pop_data, [36:32] fill_count, [39:37] zero
  output logic [rbfo_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [0] pop_valid, [1] push_accepted, [2] was_overwritten, [3] is_empty, [4] is_full
  output logic [rbfo_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

  import rbfo_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CAP_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CAP_W > CFG_DATA_W) ? CAP_W : CFG_DATA_W;

  // configuration registers
  logic                  ovw_q;
  logic [CFG_DATA_W-1:0] cap_q;

  // ring control state
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             full_q, full_d;
  state_e           state_q, state_d;

  // output register and the status held across a ram read
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic [OUT_TUSER_W-1:0] out_tuser_q;
  logic [FILL_W-1:0]      pend_fill_q;
  logic [OUT_TUSER_W-1:0] pend_tuser_q;

  logic                  accept;
  logic                  is_push, push_ok, pop_ok, empty;
  logic                  cap_wr;
  logic [CMP_W-1:0]      cap_raw;
  logic [CAP_W-1:0]      cap_eff;
  logic [CAP_W-1:0]      wr_inc, rd_inc, count;
  logic [IDX_W-1:0]      wr_adv, rd_adv;
  logic [31:0]           count_ext;
  logic [FILL_W-1:0]     fill;
  logic [OUT_TUSER_W-1:0] flags;
  logic [63:0]           push_ext, rd_ext;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [POP_DATA_W-1:0] ram_pop_data;

  // clamp the capacity register into 1..DEPTH
  assign cap_raw = CMP_W'(cap_q);
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_raw > CMP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = CAP_W'(cap_raw);
    end
  end

  // index advance with wrap at the capacity in use
  assign wr_inc = CAP_W'(wr_idx_q) + CAP_W'(1);
  assign rd_inc = CAP_W'(rd_idx_q) + CAP_W'(1);
  assign wr_adv = (wr_inc == cap_eff) ? '0 : wr_inc[IDX_W-1:0];
  assign rd_adv = (rd_inc == cap_eff) ? '0 : rd_inc[IDX_W-1:0];

  // operation decode
  assign empty   = !full_q && (wr_idx_q == rd_idx_q);
  assign is_push = (s_axis_tuser == MODE_PUSH);
  assign push_ok = is_push && (!full_q || ovw_q);
  assign pop_ok  = !is_push && !empty;
  assign cap_wr  = cfg_we_i && (cfg_idx_i == REG_CAPACITY);

  // ring state after the operation
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    full_d   = full_q;
    if (push_ok) begin
      wr_idx_d = wr_adv;
      if (full_q) begin
        rd_idx_d = rd_adv;
      end
      full_d = (wr_adv == (full_q ? rd_adv : rd_idx_q));
    end else if (pop_ok) begin
      rd_idx_d = rd_adv;
      full_d   = 1'b0;
    end
  end

  // fill count after the operation
  always_comb begin
    if (full_d) begin
      count = cap_eff;
    end else if (wr_idx_d >= rd_idx_d) begin
      count = CAP_W'(wr_idx_d) - CAP_W'(rd_idx_d);
    end else begin
      count = cap_eff - CAP_W'(rd_idx_d) + CAP_W'(wr_idx_d);
    end
  end
  assign count_ext = 32'(count);
  assign fill      = count_ext[FILL_W-1:0];

  // status flags of the result beat
  always_comb begin
    flags               = '0;
    flags[TU_POP_VALID] = pop_ok;
    flags[TU_PUSH_ACC]  = push_ok;
    flags[TU_OVERWROTE] = push_ok && full_q;
    flags[TU_EMPTY]     = (count == '0);
    flags[TU_FULL]      = full_d;
  end

  // sequencer: next state and input ready
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = !out_valid_q || m_axis_tready;
        if (s_axis_tvalid && s_axis_tready && pop_ok) begin
          state_d = ST_POP_WAIT;
        end
      end
      ST_POP_WAIT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers and ring indices
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovw_q    <= 1'b0;
      cap_q    <= CFG_DATA_W'(16);
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      full_q   <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_OVERWRITE)) begin
        ovw_q <= cfg_wdata_i[0];
      end
      if (cap_wr) begin
        cap_q    <= cfg_wdata_i;
        wr_idx_q <= '0;
        rd_idx_q <= '0;
        full_q   <= 1'b0;
      end else if (accept) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        full_q   <= full_d;
      end
    end
  end

  // slot storage
  assign push_ext  = 64'(s_axis_tdata);
  assign ram_wdata = push_ext[DATA_WIDTH-1:0];

  rbfo_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (accept && push_ok),
    .waddr_i (wr_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (accept && pop_ok),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_ext       = 64'(ram_rdata);
  assign ram_pop_data = rd_ext[POP_DATA_W-1:0];

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_POP_WAIT) begin
      out_valid_q <= 1'b1;
    end else if (accept && !pop_ok) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload and status held while the ram read completes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_POP_WAIT) begin
      out_tdata_q <= {OUT_PAD_W'(0), pend_fill_q, ram_pop_data};
      out_tuser_q <= pend_tuser_q;
    end else if (accept) begin
      if (pop_ok) begin
        pend_fill_q  <= fill;
        pend_tuser_q <= flags;
      end else begin
        out_tdata_q <= {OUT_PAD_W'(0), fill, POP_DATA_W'(0)};
        out_tuser_q <= flags;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_tdata_q;
  assign m_axis_tuser  = out_tuser_q;

endmodule

### design/rbfo_checker.sv
// port-level checks of the ring buffer fifo, bound to the top level
// depends on rbfo_pkg

module rbfo_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rbfo_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [rbfo_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  import rbfo_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a beat is either a push or a pop outcome, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[TU_POP_VALID] && m_axis_tuser[TU_PUSH_ACC]))
    else $error("pop and push flagged in one beat");

  // an overwrite only comes with an accepted push into a full ring
  a_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TU_OVERWROTE] |->
      m_axis_tuser[TU_PUSH_ACC] && m_axis_tuser[TU_FULL])
    else $error("overwrite without a full accepted push");

  // empty status agrees with the fill count
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TU_EMPTY] |->
      m_axis_tdata[POP_DATA_W +: FILL_W] == '0 && !m_axis_tuser[TU_FULL])
    else $error("empty flag with stored elements");

  // no data on a beat that popped nothing
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[TU_POP_VALID] |->
      m_axis_tdata[POP_DATA_W-1:0] == '0)
    else $error("pop data without a pop");

endmodule

bind ring_buffer_fifo_with_overwrite_top rbfo_checker u_rbfo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
